@@ sv/erxaf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erxaf_pkg
// Shared types, codes and helpers for the receive address filter.
// ----------------------------------------------------------------------------
package erxaf_pkg;

  localparam int ADDR_W        = 48;
  localparam int LEVEL_W       = 2;
  localparam int COUNT_W       = 5;
  localparam int SLOT_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int GROUP_BIT     = 40;
  localparam int TABLE_ENTRIES_DEF = 16;

  // filter levels
  localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MATCHING = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_ALL      = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UC_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BC_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_COUNT  = 3'd4;

  // item actions
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] mac_address;
    logic [SLOT_W-1:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic allow;
    logic status;
  } out_item_t;

  // control from the front end to the table search engine
  typedef struct packed {
    logic              start;
    logic              wr;
    logic [SLOT_W-1:0] wr_idx;
    logic [ADDR_W-1:0] addr;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

  function automatic logic level_pass(input logic [LEVEL_W-1:0] level, input logic match);
    level_pass = (level == LEVEL_ALL) || ((level == LEVEL_MATCHING) && match);
  endfunction

endpackage

@@ sv/erxaf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erxaf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module erxaf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/erxaf_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erxaf_search
// Multicast table store and sequential search engine, one entry per cycle.
// ----------------------------------------------------------------------------
module erxaf_search #(
  parameter int TABLE_ENTRIES = erxaf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erxaf_pkg::srch_req_t          req,
  input  logic [erxaf_pkg::COUNT_W-1:0] mc_count,
  output erxaf_pkg::srch_rsp_t          rsp
);
  import erxaf_pkg::*;

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TCW  = $clog2(TABLE_ENTRIES + 1);
  localparam int LW   = (COUNT_W > TCW) ? COUNT_W : TCW;

  localparam logic SR_IDLE = 1'b0;
  localparam logic SR_SCAN = 1'b1;

  logic                     st_r, st_nxt;
  logic [LW-1:0]            cnt_r, cnt_nxt;
  logic [LW-1:0]            limit_r, limit_nxt;
  logic [ADDR_W-1:0]        addr_r;
  logic                     hit_r, hit_nxt;
  logic                     pend_r, pend_nxt;
  logic                     vld_q_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [LW-1:0]     count_ext;
  logic [LW-1:0]     tab_size;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [ADDR_W-1:0] ram_q;
  logic              wr_ok;
  logic [AW-1:0]     wr_addr;
  logic              finish;

  assign count_ext = LW'(mc_count);
  assign tab_size  = LW'(TABLE_ENTRIES);
  assign limit_nxt = (count_ext > tab_size) ? tab_size : count_ext;

  assign rd_en   = (st_r == SR_SCAN) && (cnt_r < limit_r);
  assign rd_addr = cnt_r[AW-1:0];
  assign wr_ok   = req.wr && (int'(req.wr_idx) < TABLE_ENTRIES);
  assign wr_addr = AW'(req.wr_idx);
  assign finish  = (st_r == SR_SCAN) && !rd_en && !pend_r;

  erxaf_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (req.addr),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // read issued one cycle, compared the next
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    hit_nxt  = hit_r;
    pend_nxt = 1'b0;
    unique case (st_r)
      SR_IDLE: begin
        if (req.start) begin
          st_nxt  = SR_SCAN;
          cnt_nxt = '0;
          hit_nxt = 1'b0;
        end
      end
      SR_SCAN: begin
        pend_nxt = rd_en;
        if (rd_en) begin
          cnt_nxt = cnt_r + LW'(1);
        end
        if (pend_r && vld_q_r && (ram_q == addr_r)) begin
          hit_nxt = 1'b1;
        end
        if (finish) begin
          st_nxt = SR_IDLE;
        end
      end
      default: st_nxt = SR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= SR_IDLE;
      pend_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      if (wr_ok) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    hit_r <= hit_nxt;
    if (rd_en) begin
      vld_q_r <= valid_r[rd_addr];
    end
    if (req.start && (st_r == SR_IDLE)) begin
      addr_r  <= req.addr;
      limit_r <= limit_nxt;
    end
  end

  assign rsp.done = finish;
  assign rsp.hit  = hit_r;

endmodule

@@ sv/ethernet_rx_address_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_rx_address_filter
// Accept or reject received frames by destination address class and match.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) carries one item per frame:
// either a destination address to filter or a multicast table entry to load.
// Each item gives exactly one result on the output channel
// (out_valid / out_stall / out_data) with the allow and status bits.
// Loads, broadcast and unicast addresses and multicast addresses at levels
// none or all are settled in the transfer cycle; the result is registered
// and appears in the next cycle. A multicast address at the matching level
// walks the table, one entry per cycle through a single RAM read port and
// one 48-bit comparator, over min(multicast_count, TABLE_ENTRIES) entries;
// the next item is taken only after the search result is given.
// One item is in flight at a time; in_stall is high during a search and
// while a waiting result is held by out_stall, which keeps out_data stable.
// Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) are
// always taken; unknown indexes are ignored.
// Reset (rst_n low, synchronous) clears state, output valid and configuration
// registers, levels to none, and marks every table entry empty so it never matches until loaded.
// ----------------------------------------------------------------------------
module ethernet_rx_address_filter #(
  parameter int TABLE_ENTRIES = erxaf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  erxaf_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output erxaf_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [erxaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erxaf_pkg::ADDR_W-1:0]    cfg_data
);
  import erxaf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SRCH = 1'b1;

  logic               st_r, st_nxt;
  logic [ADDR_W-1:0]  station_r;
  logic [LEVEL_W-1:0] uc_lvl_r;
  logic [LEVEL_W-1:0] mc_lvl_r;
  logic [LEVEL_W-1:0] bc_lvl_r;
  logic [COUNT_W-1:0] mc_cnt_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic      in_acc;
  logic      is_bc;
  logic      is_mc;
  logic      need_srch;
  logic      now_allow;
  srch_req_t srch_req;
  srch_rsp_t srch_rsp;

  assign in_stall  = (st_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_bc     = (in_data.mac_address == {ADDR_W{1'b1}});
  assign is_mc     = in_data.mac_address[GROUP_BIT];
  assign need_srch = (in_data.action == ACT_FILTER) && !is_bc && is_mc &&
                     (mc_lvl_r == LEVEL_MATCHING);

  always_comb begin
    if (is_bc) begin
      now_allow = level_pass(bc_lvl_r, 1'b1);
    end else if (is_mc) begin
      now_allow = (mc_lvl_r == LEVEL_ALL);
    end else begin
      now_allow = level_pass(uc_lvl_r, station_r == in_data.mac_address);
    end
  end

  assign srch_req.start  = in_acc && need_srch;
  assign srch_req.wr     = in_acc && (in_data.action == ACT_LOAD) && is_mc;
  assign srch_req.wr_idx = in_data.entry_index;
  assign srch_req.addr   = in_data.mac_address;

  erxaf_search #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (srch_req),
    .mc_count (mc_cnt_r),
    .rsp      (srch_rsp)
  );

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (need_srch) begin
            st_nxt = ST_SRCH;
          end else begin
            out_valid_nxt = 1'b1;
            if (in_data.action == ACT_LOAD) begin
              out_data_nxt.allow  = 1'b0;
              out_data_nxt.status = !is_mc;
            end else begin
              out_data_nxt.allow  = now_allow;
              out_data_nxt.status = 1'b0;
            end
          end
        end
      end
      ST_SRCH: begin
        if (srch_rsp.done) begin
          st_nxt              = ST_IDLE;
          out_valid_nxt       = 1'b1;
          out_data_nxt.allow  = srch_rsp.hit;
          out_data_nxt.status = 1'b0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      station_r   <= '0;
      uc_lvl_r    <= LEVEL_NONE;
      mc_lvl_r    <= LEVEL_NONE;
      bc_lvl_r    <= LEVEL_NONE;
      mc_cnt_r    <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STATION:  station_r <= cfg_data;
          CFG_UC_LEVEL: uc_lvl_r  <= cfg_data[LEVEL_W-1:0];
          CFG_MC_LEVEL: mc_lvl_r  <= cfg_data[LEVEL_W-1:0];
          CFG_BC_LEVEL: bc_lvl_r  <= cfg_data[LEVEL_W-1:0];
          CFG_MC_COUNT: mc_cnt_r  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // no new item taken while the table walk runs
  a_no_accept_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SRCH) |-> in_stall)
    else $error("input transfer during table search");

  // search completion only while waiting for it
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> (st_r == ST_SRCH))
    else $error("search completion outside search state");

  // a search never overwrites a result still waiting
  a_done_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> !out_valid_r)
    else $error("search result would overwrite pending output");

  // a load transfer is answered next cycle with allow low
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.action == ACT_LOAD)) |=> (out_valid && !out_data.allow))
    else $error("load item result missing or allowing");
`endif

endmodule
